/* hdl/kmsd_pkg.sv */
// Package: shared constants, types and helpers for the key matrix scan and debounce core.
`default_nettype none
package kmsd_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLUMNS = 8;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int KEY_W       = 6;
  localparam int LEVEL_W     = 64;
  localparam int COUNT_W     = 4;
  localparam int TICK_W      = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_DEBOUNCE     = 2'd2,
    CFG_IDLE_SCAN    = 2'd3
  } kmsd_cfg_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } kmsd_state_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key_index;
    logic             key_down;
    logic             last_event;
  } kmsd_evt_t;

  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] v,
                                                   input logic [COUNT_W-1:0] max);
    sat_count = (v > max) ? max : v;
  endfunction

  function automatic logic [LEVEL_W-1:0] used_mask(input logic [COUNT_W-1:0] rows,
                                                   input logic [COUNT_W-1:0] cols);
    logic [LEVEL_W-1:0] m;
    m = '0;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        m[c*MAX_ROWS+r] = (COUNT_W'(c) < cols) && (COUNT_W'(r) < rows);
      end
    end
    used_mask = m;
  endfunction

endpackage
`default_nettype wire

/* hdl/kmsd_out_stage.sv */
// Output register: holds one key event request for the master side.
`default_nettype none
module kmsd_out_stage
  import kmsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire kmsd_evt_t  evt_i,
  output logic            free_o,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [5:0] key_index, [6] key_down, [7] zero
  output logic            m_axis_tlast   // last_event
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             down_q, down_d;
  logic             last_q, last_d;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = evt_i.valid | (valid_q & !m_axis_tready);
    key_d   = key_q;
    down_d  = down_q;
    last_d  = last_q;
    if (evt_i.valid) begin
      key_d  = evt_i.key_index;
      down_d = evt_i.key_down;
      last_d = evt_i.last_event;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    down_q <= down_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {1'b0, down_q, key_q};
  assign m_axis_tlast  = last_q;

endmodule
`default_nettype wire

/* hdl/kmsd_scan_walker.sv */
// Scan walker: steps through the used matrix positions and issues one event per changed key.
`default_nettype none
module kmsd_scan_walker
  import kmsd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [LEVEL_W-1:0] chg_i,
  input  wire logic [LEVEL_W-1:0] pressed_i,
  input  wire logic [COUNT_W-1:0] rows_i,
  input  wire logic               free_i,
  output kmsd_evt_t               evt_o,
  output logic                    busy_o
);

  kmsd_state_e        state_q, state_d;
  logic [LEVEL_W-1:0] chg_q, chg_d;
  logic [LEVEL_W-1:0] pressed_q, pressed_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [KEY_W-1:0]   key_q, key_d;

  logic [KEY_W-1:0]   pos;
  logic [LEVEL_W-1:0] rest;
  logic               hit;
  logic               last;
  logic               push;
  logic               advance;

  assign pos  = {col_q, row_q};
  assign hit  = chg_q[pos];
  assign rest = chg_q & ~(LEVEL_W'(1) << pos);
  assign last = (rest == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (hit && free_i && last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    push    = 1'b0;
    advance = 1'b0;
    busy_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
      end
      ST_WALK: begin
        busy_o  = 1'b1;
        push    = hit && free_i;
        advance = !hit || free_i;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
    evt_o.valid      = push;
    evt_o.key_index  = key_q;
    evt_o.key_down   = pressed_q[pos];
    evt_o.last_event = last;
  end

  always_comb begin
    chg_d     = chg_q;
    pressed_d = pressed_q;
    row_d     = row_q;
    col_d     = col_q;
    key_d     = key_q;
    if (start_i && (state_q == ST_IDLE)) begin
      chg_d     = chg_i;
      pressed_d = pressed_i;
      row_d     = '0;
      col_d     = '0;
      key_d     = '0;
    end else if (advance) begin
      chg_d = rest;
      key_d = key_q + KEY_W'(1);
      if ((COUNT_W'(row_q) + COUNT_W'(1)) == rows_i) begin
        row_d = '0;
        col_d = col_q + COL_W'(1);
      end else begin
        row_d = row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chg_q     <= chg_d;
    pressed_q <= pressed_d;
    row_q     <= row_d;
    col_q     <= col_d;
    key_q     <= key_d;
  end

`ifndef NO_ASSERTIONS
  a_walk_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (chg_q != '0))
    else $error("walker active with no changes left");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && last) |=> (state_q == ST_IDLE))
    else $error("walker kept going after last event");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == ST_IDLE))
    else $error("scan started while walker busy");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid |-> free_i)
    else $error("event issued into full output register");
`endif

endmodule
`default_nettype wire

/* hdl/key_matrix_scan_debounce_core.sv */
// Top level: key matrix scanner with debounce countdown and per-key change events.
//
// Slave side: one request per millisecond tick; s_axis_tdata carries the 64 active-low
// switch levels, bit column*8+row. Master side: one request per changed key, in key
// index order (column * row_count + row), tlast on the final event of a scan.
// A tick whose countdown is nonzero only decrements it and yields nothing. A scan tick
// compares the masked pressed map with the stored one and reloads the countdown with
// debounce_ticks minus one after changes, else idle_scan_ticks minus one.
// The walker registers the changed map when a scan tick is accepted, steps to index k
// and pushes that key's event into the output register that drives m_axis_tvalid.
// Throughput: a scan with changes walks one matrix position per cycle, up to
// row_count * column_count positions (64 at most), ending at the last changed key;
// s_axis_tready is low during the walk. Ticks without events are taken every cycle.
// A stall on m_axis_tready holds the walker at the next changed key.
// Reset restores the register defaults (8 rows, 8 columns, debounce 10, idle scan 1),
// an all-released map and a zero countdown, so the first tick scans.
// The configuration port (cfg_we_i, cfg_addr_i, cfg_wdata_i) is registered; the user must
// use it only while the block is idle, since the block itself does not enforce this.
`default_nettype none
module key_matrix_scan_debounce_core
  import kmsd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [LEVEL_W-1:0]    s_axis_tdata,  // [63:0] switch_levels
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [5:0] key_index, [6] key_down, [7] zero
  output logic                       m_axis_tlast   // last_event
);

  logic [COUNT_W-1:0] rows_cfg_q, rows_cfg_d;
  logic [COUNT_W-1:0] cols_cfg_q, cols_cfg_d;
  logic [TICK_W-1:0]  deb_q, deb_d;
  logic [TICK_W-1:0]  idle_q, idle_d;
  logic [LEVEL_W-1:0] prev_q, prev_d;
  logic [TICK_W-1:0]  ticks_q, ticks_d;

  logic [COUNT_W-1:0] rows_used;
  logic [COUNT_W-1:0] cols_used;
  logic [LEVEL_W-1:0] used;
  logic [LEVEL_W-1:0] pressed;
  logic [LEVEL_W-1:0] chg;
  logic [TICK_W-1:0]  interval;
  logic               in_acc;
  logic               scan;
  logic               start;
  logic               busy;
  logic               free;
  kmsd_evt_t          evt;

  assign rows_used = sat_count(rows_cfg_q, COUNT_W'(MAX_ROWS));
  assign cols_used = sat_count(cols_cfg_q, COUNT_W'(MAX_COLUMNS));
  assign used      = used_mask(rows_used, cols_used);
  assign pressed   = ~s_axis_tdata & used;
  assign chg       = (prev_q ^ pressed) & used;

  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign scan          = in_acc && (ticks_q == '0);
  assign start         = scan && (chg != '0);
  assign interval      = (chg != '0) ? deb_q : idle_q;

  always_comb begin
    rows_cfg_d = rows_cfg_q;
    cols_cfg_d = cols_cfg_q;
    deb_d      = deb_q;
    idle_d     = idle_q;
    if (cfg_we_i) begin
      case (kmsd_cfg_e'(cfg_addr_i))
        CFG_ROW_COUNT:    rows_cfg_d = cfg_wdata_i[COUNT_W-1:0];
        CFG_COLUMN_COUNT: cols_cfg_d = cfg_wdata_i[COUNT_W-1:0];
        CFG_DEBOUNCE:     deb_d      = cfg_wdata_i[TICK_W-1:0];
        CFG_IDLE_SCAN:    idle_d     = cfg_wdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prev_d  = prev_q;
    ticks_d = ticks_q;
    if (in_acc) begin
      if (ticks_q != '0) begin
        ticks_d = ticks_q - TICK_W'(1);
      end else begin
        prev_d  = pressed;
        ticks_d = (interval == '0) ? '0 : interval - TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= COUNT_W'(8);
      cols_cfg_q <= COUNT_W'(8);
      deb_q      <= TICK_W'(10);
      idle_q     <= TICK_W'(1);
      prev_q     <= '0;
      ticks_q    <= '0;
    end else begin
      rows_cfg_q <= rows_cfg_d;
      cols_cfg_q <= cols_cfg_d;
      deb_q      <= deb_d;
      idle_q     <= idle_d;
      prev_q     <= prev_d;
      ticks_q    <= ticks_d;
    end
  end

  kmsd_scan_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .chg_i     (chg),
    .pressed_i (pressed),
    .rows_i    (rows_used),
    .free_i    (free),
    .evt_o     (evt),
    .busy_o    (busy)
  );

  kmsd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_i         (evt),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_prev_in_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan |=> ((prev_q & ~$past(used)) == '0))
    else $error("stored map holds keys outside the used matrix");

  a_quiet_tick_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (ticks_q != '0)) |=> ((ticks_q == $past(ticks_q) - TICK_W'(1)) && !busy))
    else $error("countdown tick did not decrement or started a walk");

  a_change_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (busy && (ticks_q == (($past(deb_q) == '0) ? '0 : $past(deb_q) - TICK_W'(1)))))
    else $error("scan with changes did not start walk with debounce reload");
`endif

endmodule
`default_nettype wire

/* sim/kmsd_checker.sv */
// Checker: predicts key change events from observed ticks and register writes and compares them.
module kmsd_checker
  import kmsd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [LEVEL_W-1:0]    s_axis_tdata,  // [63:0] switch_levels
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [7:0]            m_axis_tdata,  // [5:0] key_index, [6] key_down, [7] zero
  input  logic                  m_axis_tlast,  // last_event
  output int                    fail_count,
  output int                    events_due,
  output int                    scans_seen,
  output int                    events_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             key_down;
    logic             key_last;
  } key_change_t;

  key_change_t        key_changes_due[$];
  logic [COUNT_W-1:0] rows_reg;
  logic [COUNT_W-1:0] cols_reg;
  logic [TICK_W-1:0]  debounce_reg;
  logic [TICK_W-1:0]  idle_reg;
  logic [TICK_W-1:0]  ticks_left;
  logic [LEVEL_W-1:0] held_map;

  initial begin
    fail_count  = 0;
    events_due  = 0;
    scans_seen  = 0;
    events_seen = 0;
  end

  function automatic logic [TICK_W-1:0] reload_from(input logic [TICK_W-1:0] interval);
    return (interval == '0) ? '0 : interval - 1'b1;
  endfunction

  function void predict_key_changes(input logic [LEVEL_W-1:0] levels);
    int                 rows;
    int                 cols;
    int                 total;
    int                 k;
    logic [LEVEL_W-1:0] used;
    logic [LEVEL_W-1:0] pressed;
    logic [LEVEL_W-1:0] changed;
    key_change_t        chg;
    if (ticks_left != '0) begin
      ticks_left = ticks_left - 1'b1;
      return;
    end
    rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    cols = (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
    used = '0;
    for (int c = 0; c < cols; c++) begin
      for (int r = 0; r < rows; r++) begin
        used[c*8+r] = 1'b1;
      end
    end
    pressed  = ~levels & used;
    changed  = (held_map ^ pressed) & used;
    held_map = pressed;
    total    = $countones(changed);
    k        = 0;
    scans_seen++;
    for (int c = 0; c < cols; c++) begin
      for (int r = 0; r < rows; r++) begin
        if (changed[c*8+r]) begin
          k++;
          chg.key_index = KEY_W'(c * rows + r);
          chg.key_down  = pressed[c*8+r];
          chg.key_last  = (k == total);
          key_changes_due.push_back(chg);
        end
      end
    end
    ticks_left = (total > 0) ? reload_from(debounce_reg) : reload_from(idle_reg);
  endfunction

  task check_key_change();
    key_change_t want;
    events_seen++;
    if (key_changes_due.size() == 0) begin
      $display("%0t: unexpected key event, actual index %0d down %0b last %0b", $time,
               m_axis_tdata[KEY_W-1:0], m_axis_tdata[KEY_W], m_axis_tlast);
      fail_count++;
    end else begin
      want = key_changes_due.pop_front();
      if (m_axis_tdata[KEY_W-1:0] !== want.key_index) begin
        $display("%0t: key_index expected %0d actual %0d", $time, want.key_index,
                 m_axis_tdata[KEY_W-1:0]);
        fail_count++;
      end
      if (m_axis_tdata[KEY_W] !== want.key_down) begin
        $display("%0t: key_down expected %0b actual %0b (index %0d)", $time, want.key_down,
                 m_axis_tdata[KEY_W], want.key_index);
        fail_count++;
      end
      if (m_axis_tlast !== want.key_last) begin
        $display("%0t: last_event expected %0b actual %0b (index %0d)", $time, want.key_last,
                 m_axis_tlast, want.key_index);
        fail_count++;
      end
      if (m_axis_tdata[7] !== 1'b0) begin
        $display("%0t: tdata pad bit expected 0 actual %0b", $time, m_axis_tdata[7]);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_reg     = 4'd8;
      cols_reg     = 4'd8;
      debounce_reg = 16'd10;
      idle_reg     = 16'd1;
      ticks_left   = '0;
      held_map     = '0;
      key_changes_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_key_change();
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_ROW_COUNT:    rows_reg     = cfg_wdata_i[COUNT_W-1:0];
          CFG_COLUMN_COUNT: cols_reg     = cfg_wdata_i[COUNT_W-1:0];
          CFG_DEBOUNCE:     debounce_reg = cfg_wdata_i[TICK_W-1:0];
          CFG_IDLE_SCAN:    idle_reg     = cfg_wdata_i[TICK_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_key_changes(s_axis_tdata);
      end
    end
    events_due = key_changes_due.size();
  end

endmodule

/* sim/tb_key_matrix_scan_debounce_core.sv */
// Testbench top: drives ticks and register writes into the key matrix scanner and reports.
module tb_key_matrix_scan_debounce_core;
  import kmsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TICKS_PER_PHASE = 24;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [LEVEL_W-1:0]    s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;

  int fail_count;
  int events_due;
  int scans_seen;
  int events_seen;

  int                 ticks_sent = 0;
  int                 settings_run = 0;
  int                 cur_rows = 8;
  int                 cur_cols = 8;
  bit                 calm = 1'b0;
  int                 rx_hold = 0;
  int                 idle_cycles;
  logic [LEVEL_W-1:0] held_keys;

  key_matrix_scan_debounce_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  kmsd_checker scan_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .events_due    (events_due),
    .scans_seen    (scans_seen),
    .events_seen   (events_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready = 1'b0;
        rx_hold--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        rx_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: watchdog expired, %0d key events still due", $time, events_due);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_key();
    if (cur_rows > 0 && cur_cols > 0 && $urandom_range(0, 4) != 0) begin
      return $urandom_range(0, cur_cols - 1) * 8 + $urandom_range(0, cur_rows - 1);
    end
    return $urandom_range(0, 63);
  endfunction

  task automatic push_tick(input logic [LEVEL_W-1:0] levels, input int gap);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = levels;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ticks_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic settle_idle();
    while (events_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input kmsd_cfg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = CFG_DATA_W'($urandom);
  endtask

  task automatic set_matrix(input logic [COUNT_W-1:0] rows, input logic [COUNT_W-1:0] cols,
                            input logic [TICK_W-1:0] debounce, input logic [TICK_W-1:0] idle);
    settle_idle();
    write_reg(CFG_ROW_COUNT, {12'($urandom), rows});
    write_reg(CFG_COLUMN_COUNT, {12'($urandom), cols});
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_IDLE_SCAN, idle);
    cur_rows = (rows > MAX_ROWS) ? MAX_ROWS : int'(rows);
    cur_cols = (cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols);
    settings_run++;
  endtask

  task automatic make_sample(output logic [LEVEL_W-1:0] levels);
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = $urandom_range(1, 3);
    if (r < 35) begin
      repeat (n) held_keys[pick_key()] = 1'b1;
    end else if (r < 65) begin
      repeat (n) held_keys[pick_key()] = 1'b0;
    end else if (r < 85) begin
      if (r >= 75) begin
        levels = ~(held_keys ^ (64'd1 << pick_key()));
        return;
      end
    end else if (r < 90) begin
      held_keys = {$urandom, $urandom};
    end else if (r < 95) begin
      held_keys = '1;
    end else begin
      held_keys = '0;
    end
    levels = ~held_keys;
  endtask

  initial begin
    logic [LEVEL_W-1:0] levels;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_ROW_COUNT;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    held_keys     = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults: first tick scans, then the debounce countdown swallows nine ticks
    push_tick('0, sender_gap());
    repeat (9) push_tick({$urandom, $urandom}, sender_gap());
    push_tick('1, sender_gap());

    set_matrix(4'd8, 4'd8, 16'd0, 16'd0);
    push_tick(~64'h1, sender_gap());
    push_tick(~64'h8000_0000_0000_0000, sender_gap());
    push_tick(~64'h8000_0000_0000_0000, sender_gap());
    push_tick(64'h5555_5555_5555_5555, sender_gap());
    push_tick(64'hAAAA_AAAA_AAAA_AAAA, sender_gap());

    set_matrix(4'd3, 4'd5, 16'd0, 16'd0);
    push_tick('0, sender_gap());
    push_tick('1, sender_gap());
    set_matrix(4'd0, 4'd8, 16'd0, 16'd0);
    push_tick('0, sender_gap());
    set_matrix(4'd15, 4'd9, 16'd0, 16'd0);
    push_tick('0, sender_gap());
    push_tick('1, sender_gap());
    set_matrix(4'd1, 4'd1, 16'd0, 16'd0);
    push_tick('0, sender_gap());
    push_tick('1, sender_gap());
    set_matrix(4'd8, 4'd0, 16'd0, 16'd0);
    push_tick('0, sender_gap());

    for (int phase = 0; phase < 6; phase++) begin
      logic [COUNT_W-1:0] rows;
      logic [COUNT_W-1:0] cols;
      if (phase == 0) begin
        rows = 4'd8;
        cols = 4'd8;
      end else if (phase == 1) begin
        rows = 4'd1;
        cols = 4'd1;
      end else if ($urandom_range(0, 6) == 0) begin
        rows = 4'($urandom_range(0, 15));
        cols = 4'($urandom_range(0, 15));
      end else begin
        rows = 4'($urandom_range(1, 8));
        cols = 4'($urandom_range(1, 8));
      end
      set_matrix(rows, cols, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 2)));
      calm = (phase == 2);
      held_keys = '0;
      repeat (TICKS_PER_PHASE) begin
        make_sample(levels);
        push_tick(levels, sender_gap());
        if ($urandom_range(0, 24) == 0) begin
          while (events_due != 0) @(negedge clk_i);
        end
      end
      calm = 1'b0;
    end

    // longer countdowns: one change, debounce wait, quiet scan, idle wait, release
    set_matrix(4'd8, 4'd8, 16'd6, 16'd4);
    levels = ~64'h0000_0100_0000_0000;
    push_tick(levels, 0);
    repeat (5) push_tick({$urandom, $urandom}, 0);
    push_tick(levels, 0);
    repeat (3) push_tick({$urandom, $urandom}, 0);
    push_tick('1, 0);

    settle_idle();
    repeat (20) @(negedge clk_i);
    $display("Run covered %0d ticks, %0d scans and %0d key events", ticks_sent, scans_seen,
             events_seen);
    $display("over %0d register settings, counts from empty to saturated.", settings_run);
    if (fail_count == 0 && events_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
